[hw/rtl/lsvh_pkg.sv]
// Shared constants, types and register codes of the safe valley heading block.
`timescale 1ns / 1ps
`default_nettype none

package lsvh_pkg;

   // Scan geometry.
   localparam int MAX_BEAMS  = 2048;
   localparam int BEAM_IDX_W = $clog2(MAX_BEAMS);
   localparam logic [BEAM_IDX_W-1:0] BEAM_IDX_LAST = BEAM_IDX_W'(MAX_BEAMS - 1);

   // Field widths.
   localparam int RANGE_W = 16;
   localparam int STEP_W  = 16;
   localparam int LIMIT_W = 12;
   localparam int ANGLE_W = 17;
   localparam int COUNT_W = 8;
   localparam int RUN_W   = 12;
   localparam logic [RUN_W-1:0]   RUN_MAX   = {RUN_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLEAR_THRESHOLD  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BEAM_ANGLE_STEP  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_VALLEY_BEAMS = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DESIRED_HEADING  = 2'd3;

   localparam logic [RANGE_W-1:0] RESET_CLEAR_THRESHOLD  = 16'd2000;
   localparam logic [STEP_W-1:0]  RESET_BEAM_ANGLE_STEP  = 16'd64;
   localparam logic [LIMIT_W-1:0] RESET_MIN_VALLEY_BEAMS = 12'd276;
   localparam logic [ANGLE_W-1:0] RESET_DESIRED_HEADING  = 17'd0;

   // Angles in Q9.8 degrees.
   localparam logic [ANGLE_W-1:0] DEG0   = 17'd0;
   localparam logic [ANGLE_W-1:0] DEG210 = 17'd53760;
   localparam logic [ANGLE_W-1:0] DEG270 = 17'd69120;
   localparam logic [ANGLE_W-1:0] DEG330 = 17'd84480;
   localparam logic [ANGLE_W-1:0] DEG360 = 17'd92160;

   // Bound arithmetic. Bounds are formed in 1/512 degree, shifted up by 4096 turns so
   // they never go negative, then halved with rounding and reduced modulo 360 degrees.
   localparam int START_W = ((BEAM_IDX_W > RUN_W) ? BEAM_IDX_W : RUN_W) + 1;
   localparam int PROD_W  = 32;
   localparam int SUM_W   = 33;
   localparam int WRAP_W  = 30;
   localparam int LOW_W   = 11;
   localparam int HIGH_W  = WRAP_W - LOW_W;
   localparam int QUOT_W  = 14;
   localparam int REM_W   = ANGLE_W - LOW_W;
   localparam int RECIP_W = 20;
   localparam int RECIP_SHIFT = 25;
   localparam int RECIP_PROD_W = HIGH_W + RECIP_W;
   // 360 degrees in Q9.8 is 45 * 2^11: the low 11 bits pass, the rest is reduced mod 45.
   localparam logic [HIGH_W-1:0]  TURN_HIGH = 19'd45;
   localparam logic [RECIP_W-1:0] RECIP     = 20'd745655;
   // One for rounding, minus 30 degrees, plus 4096 turns, all in 1/512 degree.
   localparam logic signed [SUM_W-1:0] WRAP_OFFSET = 33'sd754959361;

   localparam int CAND_N = 4;

   typedef struct packed {
      logic [RANGE_W-1:0] clear_threshold;
      logic [STEP_W-1:0]  beam_angle_step;
      logic [LIMIT_W-1:0] min_valley_beams;
      logic [ANGLE_W-1:0] desired_heading;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic [RANGE_W-1:0] range_mm;
      logic               range_invalid;
      logic               last_beam;
   } beam_type;

   typedef struct packed {
      logic                  valid;
      logic                  last;
      logic                  close;
      logic [BEAM_IDX_W-1:0] j;
      logic [RUN_W-1:0]      run;
   } run_event_type;

   typedef struct packed {
      logic               valid;
      logic               last;
      logic               close;
      logic [ANGLE_W-1:0] right;
      logic [ANGLE_W-1:0] left;
   } bound_type;

endpackage

`default_nettype wire

[hw/rtl/lsvh_req_if.sv]
// Beam input channel: valid, ready and one beam sample.
`timescale 1ns / 1ps
`default_nettype none

interface lsvh_req_if;
   logic                         valid;
   logic                         ready;
   logic [lsvh_pkg::RANGE_W-1:0] range_mm;
   logic                         range_invalid;
   logic                         last_beam;

   modport source (output valid, range_mm, range_invalid, last_beam, input ready);
   modport sink (input valid, range_mm, range_invalid, last_beam, output ready);
endinterface

`default_nettype wire

[hw/rtl/lsvh_rsp_if.sv]
// Heading result channel: valid, ready and one chosen heading.
`timescale 1ns / 1ps
`default_nettype none

interface lsvh_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [lsvh_pkg::ANGLE_W-1:0] chosen_heading;
   logic [lsvh_pkg::COUNT_W-1:0] boundary_count;

   modport source (output valid, chosen_heading, boundary_count, input ready);
   modport sink (input valid, chosen_heading, boundary_count, output ready);
endinterface

`default_nettype wire

[hw/rtl/laser_safe_valley_heading.sv]
// Top level of the laser scan safe valley heading selector.
// A result follows the last beam of a scan through the run, bound and distance stages.
// Throughput: one beam per cycle; the clear run counter and the nearest-boundary
// compare chain each close their loop combinationally. The input holds only while a
// second result reaches the result register before the first is taken.
// Synchronous reset empties the pipeline, clears the scan state and loads the defaults.
`timescale 1ns / 1ps
`default_nettype none

module laser_safe_valley_heading (
   input  wire logic                             clock,
   input  wire logic                             reset,
   lsvh_req_if.sink                              req_bus,
   lsvh_rsp_if.source                            rsp_bus,
   input  wire logic                             csr_write_en,
   input  wire logic [lsvh_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [lsvh_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   lsvh_pkg::cfg_type       cfg;
   lsvh_pkg::beam_type      beam;
   lsvh_pkg::run_event_type run_event;
   lsvh_pkg::bound_type     bound;
   logic                    stall;
   logic                    advance;

   assign advance       = !stall;
   assign req_bus.ready = advance;

   assign beam.valid         = req_bus.valid;
   assign beam.range_mm      = req_bus.range_mm;
   assign beam.range_invalid = req_bus.range_invalid;
   assign beam.last_beam     = req_bus.last_beam;

   lsvh_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   lsvh_run_tracker u_run_tracker (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .beam      (beam),
      .cfg       (cfg),
      .run_event (run_event)
   );

   lsvh_bound_calc u_bound_calc (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .run_event (run_event),
      .cfg       (cfg),
      .bound     (bound)
   );

   lsvh_selector u_selector (
      .clock              (clock),
      .reset              (reset),
      .advance            (advance),
      .bound              (bound),
      .cfg                (cfg),
      .rsp_ready          (rsp_bus.ready),
      .rsp_valid          (rsp_bus.valid),
      .rsp_chosen_heading (rsp_bus.chosen_heading),
      .rsp_boundary_count (rsp_bus.boundary_count),
      .stall              (stall)
   );

   // Without any boundary the heading is either the requested one inside the rear
   // sector or the default, both of which lie between 210 and 330 degrees.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.boundary_count == '0)) |->
      ((rsp_bus.chosen_heading >= lsvh_pkg::DEG210) &&
       (rsp_bus.chosen_heading <= lsvh_pkg::DEG330)))
      else $error("heading outside the rear sector with no boundary");

   // Every emitted heading is a wrapped boundary, the default or the desired heading.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.chosen_heading <= lsvh_pkg::DEG360))
      else $error("chosen heading beyond a full turn");

   // Input is refused only while a result waits at the output.
   assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (rsp_bus.valid && !rsp_bus.ready))
      else $error("input stalled without a pending result");

endmodule

`default_nettype wire

[hw/rtl/lsvh_csr.sv]
// Configuration registers of the safe valley heading block.
`timescale 1ns / 1ps
`default_nettype none

module lsvh_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_en,
   input  wire logic [lsvh_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [lsvh_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output lsvh_pkg::cfg_type                     cfg
);

   lsvh_pkg::cfg_type cfg_ff;
   lsvh_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            lsvh_pkg::CSR_CLEAR_THRESHOLD: begin
               cfg_in.clear_threshold = csr_write_data[lsvh_pkg::RANGE_W-1:0];
            end
            lsvh_pkg::CSR_BEAM_ANGLE_STEP: begin
               cfg_in.beam_angle_step = csr_write_data[lsvh_pkg::STEP_W-1:0];
            end
            lsvh_pkg::CSR_MIN_VALLEY_BEAMS: begin
               cfg_in.min_valley_beams = csr_write_data[lsvh_pkg::LIMIT_W-1:0];
            end
            lsvh_pkg::CSR_DESIRED_HEADING: begin
               cfg_in.desired_heading = csr_write_data[lsvh_pkg::ANGLE_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clear_threshold  <= lsvh_pkg::RESET_CLEAR_THRESHOLD;
         cfg_ff.beam_angle_step  <= lsvh_pkg::RESET_BEAM_ANGLE_STEP;
         cfg_ff.min_valley_beams <= lsvh_pkg::RESET_MIN_VALLEY_BEAMS;
         cfg_ff.desired_heading  <= lsvh_pkg::RESET_DESIRED_HEADING;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[hw/rtl/lsvh_run_tracker.sv]
// Input register, clear run counter and beam index; flags each closed valley.
`timescale 1ns / 1ps
`default_nettype none

module lsvh_run_tracker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  lsvh_pkg::beam_type     beam,
   input  lsvh_pkg::cfg_type      cfg,
   output lsvh_pkg::run_event_type run_event
);

   lsvh_pkg::beam_type beam_ff;

   logic [lsvh_pkg::BEAM_IDX_W-1:0] beam_index_ff;
   logic [lsvh_pkg::BEAM_IDX_W-1:0] beam_index_in;
   logic [lsvh_pkg::RUN_W-1:0]      clear_run_ff;
   logic [lsvh_pkg::RUN_W-1:0]      clear_run_in;
   lsvh_pkg::run_event_type         event_ff;
   lsvh_pkg::run_event_type         event_in;

   logic                       is_clear;
   logic [lsvh_pkg::RUN_W-1:0] run_grown;

   always_comb begin
      is_clear  = beam_ff.range_invalid || (beam_ff.range_mm >= cfg.clear_threshold);
      run_grown = (clear_run_ff < lsvh_pkg::RUN_MAX) ? clear_run_ff + 1'b1 : clear_run_ff;

      event_in.valid = beam_ff.valid;
      event_in.last  = beam_ff.last_beam;
      event_in.j     = beam_index_ff;
      event_in.close = 1'b0;
      event_in.run   = clear_run_ff;
      clear_run_in   = clear_run_ff;
      beam_index_in  = beam_index_ff;

      if (beam_ff.valid) begin
         // An obstacle beam or the last beam ends the run; a clear last beam joins it.
         if (!is_clear || beam_ff.last_beam) begin
            event_in.run   = is_clear ? run_grown : clear_run_ff;
            event_in.close = (event_in.run != '0) &&
                             (event_in.run >= lsvh_pkg::RUN_W'(cfg.min_valley_beams));
            clear_run_in   = '0;
         end else begin
            clear_run_in = run_grown;
         end

         if (beam_ff.last_beam) begin
            beam_index_in = '0;
         end else if (beam_index_ff < lsvh_pkg::BEAM_IDX_LAST) begin
            beam_index_in = beam_index_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beam_ff.valid  <= 1'b0;
         event_ff.valid <= 1'b0;
         beam_index_ff  <= '0;
         clear_run_ff   <= '0;
      end else if (advance) begin
         beam_ff        <= beam;
         event_ff       <= event_in;
         beam_index_ff  <= beam_index_in;
         clear_run_ff   <= clear_run_in;
      end
   end

   assign run_event = event_ff;

endmodule

`default_nettype wire

[hw/rtl/lsvh_bound_calc.sv]
// Four-stage pipeline that turns a closed valley into wrapped right and left bounds.
`timescale 1ns / 1ps
`default_nettype none

module lsvh_bound_calc (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  lsvh_pkg::run_event_type run_event,
   input  lsvh_pkg::cfg_type       cfg,
   output lsvh_pkg::bound_type     bound
);

   localparam int RIGHT = 0;
   localparam int LEFT  = 1;

   // Control travelling alongside the data: valid, last, close.
   logic [2:0] ctl2_ff;
   logic [2:0] ctl3_ff;
   logic [2:0] ctl4_ff;
   logic [2:0] ctl5_ff;

   // Stage 2: products.
   logic signed [lsvh_pkg::START_W-1:0] start_s;
   logic signed [lsvh_pkg::PROD_W-1:0]  start_ext;
   logic signed [lsvh_pkg::PROD_W-1:0]  step_ext;
   logic signed [lsvh_pkg::PROD_W-1:0]  ps_in;
   logic signed [lsvh_pkg::PROD_W-1:0]  ps_ff;
   logic [lsvh_pkg::PROD_W-1:0]         pj_in;
   logic [lsvh_pkg::PROD_W-1:0]         pj_ff;
   logic [lsvh_pkg::PROD_W-1:0]         pl_in;
   logic [lsvh_pkg::PROD_W-1:0]         pl_ff;

   // Stage 3: biased, rounded half-unit sums.
   logic signed [lsvh_pkg::SUM_W-1:0] sum_r;
   logic signed [lsvh_pkg::SUM_W-1:0] sum_l;
   logic [lsvh_pkg::WRAP_W-1:0]       u_in [2];
   logic [lsvh_pkg::WRAP_W-1:0]       u_ff [2];

   // Stage 4: quotient by 45 of the upper bits.
   logic [lsvh_pkg::RECIP_PROD_W-1:0] recip_prod [2];
   logic [lsvh_pkg::HIGH_W-1:0]       high_ff [2];
   logic [lsvh_pkg::LOW_W-1:0]        low_ff [2];
   logic [lsvh_pkg::QUOT_W-1:0]       quot_in [2];
   logic [lsvh_pkg::QUOT_W-1:0]       quot_ff [2];

   // Stage 5: remainder and wrapped angle.
   logic [lsvh_pkg::HIGH_W-1:0]  rem_full [2];
   logic [lsvh_pkg::ANGLE_W-1:0] angle_in [2];
   logic [lsvh_pkg::ANGLE_W-1:0] angle_ff [2];

   always_comb begin
      start_s = $signed({{(lsvh_pkg::START_W-lsvh_pkg::BEAM_IDX_W){1'b0}}, run_event.j})
              - $signed({{(lsvh_pkg::START_W-lsvh_pkg::RUN_W){1'b0}}, run_event.run});
      start_ext = lsvh_pkg::PROD_W'(start_s);
      step_ext  = $signed({{(lsvh_pkg::PROD_W-lsvh_pkg::STEP_W){1'b0}}, cfg.beam_angle_step});
      ps_in = start_ext * step_ext;
      pj_in = lsvh_pkg::PROD_W'(run_event.j) * lsvh_pkg::PROD_W'(cfg.beam_angle_step);
      pl_in = lsvh_pkg::PROD_W'(cfg.min_valley_beams) * lsvh_pkg::PROD_W'(cfg.beam_angle_step);
   end

   always_comb begin
      sum_r = (lsvh_pkg::SUM_W'(ps_ff) <<< 1) + $signed({1'b0, pl_ff}) + lsvh_pkg::WRAP_OFFSET;
      sum_l = ($signed({1'b0, pj_ff}) <<< 1) - $signed({1'b0, pl_ff}) + lsvh_pkg::WRAP_OFFSET;
      u_in[RIGHT] = sum_r[lsvh_pkg::WRAP_W:1];
      u_in[LEFT]  = sum_l[lsvh_pkg::WRAP_W:1];
   end

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         recip_prod[k] = lsvh_pkg::RECIP_PROD_W'(u_ff[k][lsvh_pkg::WRAP_W-1:lsvh_pkg::LOW_W])
                       * lsvh_pkg::RECIP_PROD_W'(lsvh_pkg::RECIP);
         quot_in[k] = recip_prod[k][lsvh_pkg::RECIP_SHIFT+lsvh_pkg::QUOT_W-1:lsvh_pkg::RECIP_SHIFT];
      end
   end

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         rem_full[k] = high_ff[k]
                     - (lsvh_pkg::HIGH_W'(quot_ff[k]) * lsvh_pkg::TURN_HIGH);
         angle_in[k] = {rem_full[k][lsvh_pkg::REM_W-1:0], low_ff[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
         ctl5_ff <= '0;
      end else if (advance) begin
         ctl2_ff <= {run_event.valid, run_event.last, run_event.close};
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
         ctl5_ff <= ctl4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ps_ff <= ps_in;
         pj_ff <= pj_in;
         pl_ff <= pl_in;
         for (int k = 0; k < 2; k++) begin
            u_ff[k]     <= u_in[k];
            high_ff[k]  <= u_ff[k][lsvh_pkg::WRAP_W-1:lsvh_pkg::LOW_W];
            low_ff[k]   <= u_ff[k][lsvh_pkg::LOW_W-1:0];
            quot_ff[k]  <= quot_in[k];
            angle_ff[k] <= angle_in[k];
         end
      end
   end

   assign bound.valid = ctl5_ff[2];
   assign bound.last  = ctl5_ff[1];
   assign bound.close = ctl5_ff[0];
   assign bound.right = angle_ff[RIGHT];
   assign bound.left  = angle_ff[LEFT];

endmodule

`default_nettype wire

[hw/rtl/lsvh_selector.sv]
// Boundary distances, nearest-boundary state and the result register.
`timescale 1ns / 1ps
`default_nettype none

module lsvh_selector (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  lsvh_pkg::bound_type                bound,
   input  lsvh_pkg::cfg_type                  cfg,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic [lsvh_pkg::ANGLE_W-1:0]       rsp_chosen_heading,
   output logic [lsvh_pkg::COUNT_W-1:0]       rsp_boundary_count,
   output logic                               stall
);

   localparam int CAND_N = lsvh_pkg::CAND_N;

   // Distance stage.
   logic                         valid6_ff;
   logic                         last6_ff;
   logic                         hit_in;
   logic                         hit_ff;
   logic [CAND_N-1:0]            use_in;
   logic [CAND_N-1:0]            use_ff;
   logic [lsvh_pkg::ANGLE_W-1:0] cand_in [CAND_N];
   logic [lsvh_pkg::ANGLE_W-1:0] cand_ff [CAND_N];
   logic [lsvh_pkg::ANGLE_W-1:0] dist_in [CAND_N];
   logic [lsvh_pkg::ANGLE_W-1:0] dist_ff [CAND_N];
   logic                         split;

   // Scan state.
   logic                         inside_ff;
   logic                         inside_in;
   logic [lsvh_pkg::ANGLE_W-1:0] best_dist_ff;
   logic [lsvh_pkg::ANGLE_W-1:0] best_dist_in;
   logic [lsvh_pkg::ANGLE_W-1:0] best_bound_ff;
   logic [lsvh_pkg::ANGLE_W-1:0] best_bound_in;
   logic [lsvh_pkg::COUNT_W-1:0] count_ff;
   logic [lsvh_pkg::COUNT_W-1:0] count_in;

   // Result register.
   logic                         rsp_valid_ff;
   logic [lsvh_pkg::ANGLE_W-1:0] rsp_heading_ff;
   logic [lsvh_pkg::ANGLE_W-1:0] rsp_heading_in;
   logic [lsvh_pkg::COUNT_W-1:0] rsp_count_ff;
   logic                         emit;

   // Smaller of the direct distance and the distance one turn up, which floors at zero.
   function automatic logic [lsvh_pkg::ANGLE_W-1:0] bound_distance(
      input logic [lsvh_pkg::ANGLE_W-1:0] b,
      input logic [lsvh_pkg::ANGLE_W-1:0] h
   );
      logic [lsvh_pkg::ANGLE_W-1:0] d1;
      logic [lsvh_pkg::ANGLE_W:0]   up;
      logic [lsvh_pkg::ANGLE_W:0]   d2;
      d1 = (b > h) ? (b - h) : (h - b);
      up = {1'b0, b} + {1'b0, lsvh_pkg::DEG360};
      d2 = (up < {1'b0, h}) ? '0 : (up - {1'b0, h});
      return ({1'b0, d1} > d2) ? d2[lsvh_pkg::ANGLE_W-1:0] : d1;
   endfunction

   always_comb begin
      split      = bound.right > bound.left;
      use_in     = '0;
      hit_in     = 1'b0;
      cand_in[0] = bound.right;
      cand_in[1] = split ? lsvh_pkg::DEG360 : bound.left;
      cand_in[2] = lsvh_pkg::DEG0;
      cand_in[3] = bound.left;
      if (bound.close) begin
         if (split) begin
            use_in = 4'b1111;
            hit_in = ((cfg.desired_heading >= bound.right) &&
                      (cfg.desired_heading <= lsvh_pkg::DEG360)) ||
                     (cfg.desired_heading <= bound.left);
         end else begin
            use_in = 4'b0011;
            hit_in = (cfg.desired_heading >= bound.right) &&
                     (cfg.desired_heading <= bound.left);
         end
      end
      for (int k = 0; k < CAND_N; k++) begin
         dist_in[k] = bound_distance(cand_in[k], cfg.desired_heading);
      end
   end

   // Boundaries are taken in order; a later one wins only when strictly nearer.
   always_comb begin
      best_dist_in  = best_dist_ff;
      best_bound_in = best_bound_ff;
      count_in      = count_ff;
      for (int k = 0; k < CAND_N; k++) begin
         if (use_ff[k]) begin
            if ((count_in == '0) || (dist_ff[k] < best_dist_in)) begin
               best_dist_in  = dist_ff[k];
               best_bound_in = cand_ff[k];
            end
            if (count_in != lsvh_pkg::COUNT_MAX) begin
               count_in = count_in + 1'b1;
            end
         end
      end
      inside_in = inside_ff || hit_ff;

      if (inside_in || ((cfg.desired_heading >= lsvh_pkg::DEG210) &&
                        (cfg.desired_heading <= lsvh_pkg::DEG330))) begin
         rsp_heading_in = cfg.desired_heading;
      end else if (count_in == '0) begin
         rsp_heading_in = lsvh_pkg::DEG270;
      end else begin
         rsp_heading_in = best_bound_in;
      end
   end

   assign stall = valid6_ff && last6_ff && rsp_valid_ff && !rsp_ready;
   assign emit  = advance && valid6_ff && last6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid6_ff     <= 1'b0;
         inside_ff     <= 1'b0;
         best_dist_ff  <= '1;
         best_bound_ff <= '0;
         count_ff      <= '0;
      end else if (advance) begin
         valid6_ff <= bound.valid;
         if (valid6_ff) begin
            if (last6_ff) begin
               inside_ff     <= 1'b0;
               best_dist_ff  <= '1;
               best_bound_ff <= '0;
               count_ff      <= '0;
            end else begin
               inside_ff     <= inside_in;
               best_dist_ff  <= best_dist_in;
               best_bound_ff <= best_bound_in;
               count_ff      <= count_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         last6_ff <= bound.last;
         hit_ff   <= hit_in;
         use_ff   <= use_in;
         for (int k = 0; k < CAND_N; k++) begin
            cand_ff[k] <= cand_in[k];
            dist_ff[k] <= dist_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_heading_ff <= rsp_heading_in;
         rsp_count_ff   <= count_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_chosen_heading = rsp_heading_ff;
   assign rsp_boundary_count = rsp_count_ff;

endmodule

`default_nettype wire
